// ===== sv/integer_to_roman_encoder_macros.svh =====
// ---------------------------------------------------------------------------
// integer_to_roman_encoder assertion macros
// Concurrent assertion shorthands, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_ENCODER_MACROS_SVH
`define INTEGER_TO_ROMAN_ENCODER_MACROS_SVH

// same-cycle implication
`define I2R_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2r assertion failed");

// next-cycle implication
`define I2R_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2r assertion failed");

`endif

// ===== sv/i2r_pkg.sv =====
// ---------------------------------------------------------------------------
// i2r_pkg
// Shared types, letter codes and digit pattern tables for the Roman encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package i2r_pkg;

  localparam logic [11:0] VALUE_MAX = 12'd3999;

  localparam logic [6:0] CH_I = 7'd73;
  localparam logic [6:0] CH_V = 7'd86;
  localparam logic [6:0] CH_X = 7'd88;
  localparam logic [6:0] CH_L = 7'd76;
  localparam logic [6:0] CH_C = 7'd67;
  localparam logic [6:0] CH_D = 7'd68;
  localparam logic [6:0] CH_M = 7'd77;

  // decimal orders
  localparam logic [1:0] ORD_UNIT = 2'd0;
  localparam logic [1:0] ORD_TEN  = 2'd1;
  localparam logic [1:0] ORD_HUND = 2'd2;
  localparam logic [1:0] ORD_THOU = 2'd3;

  // letter roles within an order
  localparam logic [1:0] ROLE_ONE  = 2'd0;
  localparam logic [1:0] ROLE_FIVE = 2'd1;
  localparam logic [1:0] ROLE_TEN  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SPLIT = 3'b010,
    ST_EMIT  = 3'b100
  } i2r_state_e;

  typedef struct packed {
    logic load;
    logic split;
    logic emit;
  } i2r_cmd_t;

  typedef struct packed {
    logic in_ok;
    logic split_last;
    logic out_free;
    logic emit_last;
  } i2r_status_t;

  function automatic logic [13:0] order_weight(logic [1:0] ord);
    logic [13:0] w;
    case (ord)
      ORD_THOU: w = 14'd1000;
      ORD_HUND: w = 14'd100;
      ORD_TEN:  w = 14'd10;
      default:  w = 14'd1;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] digit_len(logic [3:0] dig);
    logic [2:0] n;
    case (dig)
      4'd1, 4'd5:       n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:             n = 3'd2;
      4'd3, 4'd7:       n = 3'd3;
      4'd8:             n = 3'd4;
      default:          n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] digit_role(logic [3:0] dig, logic [1:0] pos);
    logic [1:0] r;
    r = ROLE_ONE;
    case (dig)
      4'd4: if (pos == 2'd1) r = ROLE_FIVE;
      4'd5, 4'd6, 4'd7, 4'd8: if (pos == 2'd0) r = ROLE_FIVE;
      4'd9: if (pos == 2'd1) r = ROLE_TEN;
      default: r = ROLE_ONE;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] order_letter(logic [1:0] ord, logic [1:0] role);
    logic [6:0] c;
    case (ord)
      ORD_UNIT: c = (role == ROLE_ONE) ? CH_I : (role == ROLE_FIVE) ? CH_V : CH_X;
      ORD_TEN:  c = (role == ROLE_ONE) ? CH_X : (role == ROLE_FIVE) ? CH_L : CH_C;
      ORD_HUND: c = (role == ROLE_ONE) ? CH_C : (role == ROLE_FIVE) ? CH_D : CH_M;
      default:  c = CH_M;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/integer_to_roman_encoder.sv =====
// ---------------------------------------------------------------------------
// integer_to_roman_encoder
// Binary integer to subtractive Roman numeral, one ASCII letter per beat.
// ---------------------------------------------------------------------------
// A request carries a value 1..3999 and produces its numeral most significant
// letter first, tlast on the final letter; zero or values above 3999 are taken
// and dropped with no output. After a request is accepted, the digit splitter
// runs one compare ladder step each for thousands, hundreds and tens, then the
// letter pointer issues one letter per cycle into the output register while
// the output is not stalled. The next request is taken while the last letter
// still sits in the output register.
`default_nettype none
`include "integer_to_roman_encoder_macros.svh"

module integer_to_roman_encoder
  import i2r_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [11:0] value, [15:12] zero
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [7:0]  m_axis_tdata_o,   // [6:0] symbol, [7] zero
  output      logic        m_axis_tlast_o
);

  i2r_cmd_t    cmd;
  i2r_status_t status;
  logic [6:0]  symbol;

  i2r_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2r_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (s_axis_tdata_i[11:0]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_symbol_o (symbol),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, symbol};

  `I2R_ASSERT_NEXT(a_load_busy, cmd.load, !s_axis_tready_o && cmd.split)
  `I2R_ASSERT_NEXT(a_split_to_emit, cmd.split && status.split_last, !s_axis_tready_o && !cmd.split)
  `I2R_ASSERT_NEXT(a_last_frees, cmd.emit && status.emit_last, s_axis_tready_o && m_axis_tlast_o)
  `I2R_ASSERT_IMPL(a_letter_legal, m_axis_tvalid_o,
                   symbol == CH_I || symbol == CH_V || symbol == CH_X || symbol == CH_L ||
                   symbol == CH_C || symbol == CH_D || symbol == CH_M)

endmodule

`default_nettype wire

// ===== sv/i2r_ctrl.sv =====
// ---------------------------------------------------------------------------
// i2r_ctrl
// Sequencer: accept, three digit-split steps, then one letter per slot.
// ---------------------------------------------------------------------------
`default_nettype none

module i2r_ctrl
  import i2r_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire i2r_status_t status_i,
  output      i2r_cmd_t    cmd_o
);

  i2r_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // zero and out-of-range requests are dropped here
        if (in_valid_i && status_i.in_ok) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
        if (status_i.split_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2r_dpath.sv =====
// ---------------------------------------------------------------------------
// i2r_dpath
// Digit splitter, letter pointer and output register of the Roman encoder.
// ---------------------------------------------------------------------------
`default_nettype none

module i2r_dpath
  import i2r_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [11:0] value_i,
  input  wire i2r_cmd_t    cmd_i,
  output      i2r_status_t status_o,
  input  wire logic        out_ready_i,
  output      logic        out_valid_o,
  output      logic [6:0]  out_symbol_o,
  output      logic        out_last_o
);

  logic [11:0] rem_q;
  logic [3:0]  dig_q [4];
  logic [1:0]  ord_q;
  logic [1:0]  pos_q;
  logic        out_valid_q;
  logic [6:0]  out_symbol_q;
  logic        out_last_q;

  // split step: one decimal digit by a compare ladder against the order weight
  logic [13:0] weight;
  logic [3:0]  split_dig;
  logic [13:0] split_sub;
  logic [11:0] rem_nxt;

  always_comb begin
    weight    = order_weight(ord_q);
    split_dig = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if ({2'b00, rem_q} >= 14'(j) * weight) split_dig = 4'(j);
    end
    split_sub = 14'(split_dig) * weight;
    rem_nxt   = 12'({2'b00, rem_q} - split_sub);
  end

  // letter pointer: skip orders whose digit is zero
  logic [3:0] nz;
  logic [1:0] eff;
  logic       found;
  logic       lower_nz;
  logic [2:0] len;
  logic       pos_end;
  logic [6:0] letter;

  always_comb begin
    for (int k = 0; k < 4; k++) nz[k] = (dig_q[k] != 4'd0);
    eff   = ORD_UNIT;
    found = 1'b0;
    for (int k = 3; k >= 0; k--) begin
      if (!found && (2'(k) <= ord_q) && nz[k]) begin
        eff   = 2'(k);
        found = 1'b1;
      end
    end
    lower_nz = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if ((2'(k) < eff) && nz[k]) lower_nz = 1'b1;
    end
    len     = digit_len(dig_q[eff]);
    pos_end = (({1'b0, pos_q} + 3'd1) == len);
    letter  = order_letter(eff, digit_role(dig_q[eff], pos_q));
  end

  assign status_o.in_ok      = (value_i != 12'd0) && (value_i <= VALUE_MAX);
  assign status_o.split_last = (ord_q == ORD_TEN);
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.emit_last  = pos_end && !lower_nz;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= value_i;
    end else if (cmd_i.split) begin
      rem_q        <= rem_nxt;
      dig_q[ord_q] <= split_dig;
      if (ord_q == ORD_TEN) dig_q[ORD_UNIT] <= rem_nxt[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_q <= ORD_THOU;
      pos_q <= 2'd0;
    end else if (cmd_i.load) begin
      ord_q <= ORD_THOU;
      pos_q <= 2'd0;
    end else if (cmd_i.split) begin
      ord_q <= (ord_q == ORD_TEN) ? ORD_THOU : ord_q - 2'd1;
      pos_q <= 2'd0;
    end else if (cmd_i.emit) begin
      if (pos_end) begin
        ord_q <= eff - 2'd1;
        pos_q <= 2'd0;
      end else begin
        ord_q <= eff;
        pos_q <= pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_symbol_q <= letter;
      out_last_q   <= status_o.emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_symbol_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

// ===== bench/integer_to_roman_encoder_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// integer_to_roman_encoder_tb
// Streams integers into the encoder and checks every letter and tlast against
// a local Roman numeral predictor, under random bursts, gaps and output stalls.
// ---------------------------------------------------------------------------

module integer_to_roman_encoder_tb;
  import i2r_pkg::*;

  typedef struct {
    logic [6:0] symbol;
    logic       last;
  } letter_t;

  typedef struct {
    logic [11:0] value;
    bit          drain;   // hold this request until all letters are out
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;    // [11:0] value, [15:12] zero
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;         // [6:0] symbol, [7] zero
  logic        m_axis_tlast_o;

  request_t    request_q[$];
  letter_t     numeral_q[$];
  logic        req_taken = 1'b0;
  int unsigned reqs_in = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  int unsigned burst_left = 4;
  int unsigned gap_left = 0;
  logic [7:0]  ready_pattern = 8'hFF;
  int unsigned pattern_age = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  logic [11:0] directed_values [24] = '{
    12'd0, 12'd1, 12'd4095, 12'd4000, 12'd3999, 12'd3888, 12'd4, 12'd9,
    12'd5, 12'd8, 12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd3000,
    12'd2444, 12'd1994, 12'd500, 12'd50, 12'd2730, 12'd1365, 12'd3, 12'd2
  };

  integer_to_roman_encoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Appends the letters of one value, most significant first.
  function automatic void predict_numeral(logic [11:0] value);
    letter_t     word[$];
    letter_t     l;
    int unsigned dig;
    int unsigned weight;
    logic [6:0]  one, five, ten;
    if (value == 12'd0 || value > VALUE_MAX) return;
    for (int ord = 3; ord >= 0; ord--) begin
      case (ord)
        3: begin weight = 1000; one = CH_M; five = CH_M; ten = CH_M; end
        2: begin weight = 100;  one = CH_C; five = CH_D; ten = CH_M; end
        1: begin weight = 10;   one = CH_X; five = CH_L; ten = CH_C; end
        default: begin weight = 1; one = CH_I; five = CH_V; ten = CH_X; end
      endcase
      dig = (value / weight) % 10;
      l.last = 1'b0;
      case (dig)
        4: begin
          l.symbol = one;  word.push_back(l);
          l.symbol = five; word.push_back(l);
        end
        9: begin
          l.symbol = one; word.push_back(l);
          l.symbol = ten; word.push_back(l);
        end
        5, 6, 7, 8: begin
          l.symbol = five; word.push_back(l);
          l.symbol = one;
          repeat (dig - 5) word.push_back(l);
        end
        default: begin
          l.symbol = one;
          repeat (dig) word.push_back(l);
        end
      endcase
    end
    for (int i = 0; i < word.size(); i++) begin
      l = word[i];
      l.last = (i == word.size() - 1);
      numeral_q.push_back(l);
    end
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int queue_value(logic [11:0] value, bit drain);
    request_t r;
    r.value = value;
    r.drain = drain;
    request_q.push_back(r);
    return (value != 12'd0 && value <= VALUE_MAX) ? 1 : 0;
  endfunction

  // request driver
  always @(negedge clk_i) begin
    request_t item;
    bit       offer;
    if (rst_ni && !(s_axis_tvalid_i && !req_taken)) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() > 0 &&
                   !(request_q[0].drain && numeral_q.size() != 0)) begin
        item = request_q.pop_front();
        offer = 1'b1;
        s_axis_tdata_i <= {4'b0000, item.value};
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                   : $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25)
                                                 : $urandom_range(0, 4);
        end
      end
      s_axis_tvalid_i <= offer;
    end
  end

  // letter receiver; one long hold after the first requests back the block up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && reqs_in >= 30) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) hold_left--;
      pattern_age++;
      if (pattern_age == 48) begin
        pattern_age = 0;
        ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
      end
      ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
      m_axis_tready_i <= (hold_left == 0) && ready_pattern[0];
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    letter_t want;
    if (rst_ni) begin
      req_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (numeral_q.size() == 0) begin
          report_mismatch("unexpected letter", m_axis_tdata_o, 8'd0);
        end else begin
          want = numeral_q.pop_front();
          if (m_axis_tdata_o[6:0] !== want.symbol)
            report_mismatch("symbol", {1'b0, m_axis_tdata_o[6:0]}, {1'b0, want.symbol});
          if (m_axis_tlast_o !== want.last)
            report_mismatch("tlast", {7'd0, m_axis_tlast_o}, {7'd0, want.last});
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_numeral(s_axis_tdata_i[11:0]);
        reqs_in++;
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 3000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int valid_cnt;
    int pick;
    valid_cnt = 0;
    // directed: extremes, out of range, and a spread of digit patterns across the orders
    foreach (directed_values[i])
      void'(queue_value(directed_values[i], i == 12));
    valid_cnt = 0;
    while (valid_cnt < 85) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        void'(queue_value(12'd0, 1'b0));
      else if (pick == 1)
        void'(queue_value(12'($urandom_range(4000, 4095)), 1'b0));
      else if (pick == 2)
        valid_cnt += queue_value(12'($urandom_range(3000, 3999)), 1'b0);
      else
        valid_cnt += queue_value(12'($urandom_range(1, 3999)),
                                 $urandom_range(0, 39) == 0);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (numeral_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
